>>> sv/assert_macros.svh
// assertion macros for the rtl, included by bfu_decode
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> sv/bfu_pkg.sv
// package for the binary field unpacker: codes, types, decode function
// no dependencies
package bfu_pkg;

  typedef enum logic [3:0] {
    FN_C   = 4'd0,
    FN_SB  = 4'd1,
    FN_UB  = 4'd2,
    FN_SH  = 4'd3,
    FN_UH  = 4'd4,
    FN_SL  = 4'd5,
    FN_UL  = 4'd6,
    FN_F   = 4'd7,
    FN_D   = 4'd8,
    FN_SI  = 4'd9,
    FN_UI  = 4'd10,
    FN_PAD = 4'd11
  } func_e;

  typedef enum logic [1:0] {
    KIND_UINT = 2'd0,
    KIND_SINT = 2'd1,
    KIND_CHAR = 2'd2,
    KIND_DBL  = 2'd3
  } kind_e;

  localparam logic [1:0] REG_BIG_ENDIAN = 2'd0;
  localparam logic [1:0] REG_NATIVE     = 2'd1;
  localparam logic [2:0] NATIVE_RESET   = 3'd4;

  typedef struct packed {
    logic       big_endian;
    logic [2:0] native_int_bytes;
  } cfg_t;

  // join n bytes in stream order
  function automatic logic [63:0] join_bytes(logic [63:0] raw, logic [3:0] n, logic be);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        if (be) w[8*(int'(n)-1-i) +: 8] = raw[8*i +: 8];
        else    w[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return w;
  endfunction

  // single float to double bits; exponent 255 is widened like a normal exponent, so inf and nan stay finite
  function automatic logic [63:0] sgl_to_dbl(logic [31:0] w);
    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  p;
    logic [51:0] fr;
    logic [10:0] de;
    e = w[30:23];
    f = w[22:0];
    p = '0;
    for (int i = 0; i < 23; i++) if (f[i]) p = 5'(i);
    fr = '0;
    de = '0;
    if (e == 8'd0) begin
      if (f != 23'd0) begin
        de = 11'(p) + 11'd874;
        fr = 52'({29'd0, f} << (6'd52 - 6'(p)));
      end
    end else begin
      de = 11'(e) + 11'd896;
      fr = {f, 29'd0};
    end
    return {w[31], de, fr};
  endfunction

endpackage

>>> sv/bfu_cfg.sv
// apb register file for the binary field unpacker
// depends on bfu_pkg
module bfu_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output bfu_pkg::cfg_t cfg_o
);
  import bfu_pkg::*;
  cfg_t cfg_q, cfg_d;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  // register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr && paddr[1:0] == 2'd0) begin
      if (paddr[2] == REG_BIG_ENDIAN[0]) cfg_d.big_endian = pwdata[0];
      else cfg_d.native_int_bytes = pwdata[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{big_endian: 1'b0, native_int_bytes: NATIVE_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NATIVE[0]) prdata[2:0] = cfg_q.native_int_bytes;
    else prdata[0] = cfg_q.big_endian;
  end

  assign cfg_o = cfg_q;
endmodule

>>> sv/bfu_decode.sv
// decode stage: input register, combinational decode, result register
// depends on bfu_pkg and assert_macros.svh
`include "assert_macros.svh"
module bfu_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfu_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [3:0]    in_func_i,
  input  logic [63:0]   in_raw_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   out_value_o,
  output logic [1:0]    out_kind_o
);
  import bfu_pkg::*;

  logic        a_vld_q;
  logic [3:0]  a_func_q;
  logic [63:0] a_raw_q;
  logic        b_vld_q;
  logic [63:0] b_val_q;
  logic [1:0]  b_kind_q;
  logic        b_free, a_adv, a_res;
  logic [63:0] val;
  kind_e       kind;
  logic [3:0]  n;
  logic        sgn;
  logic [63:0] w;
  logic [3:0]  nat;

  assign b_free = ~b_vld_q | out_ready_i;
  assign a_adv = ~a_vld_q | b_free;
  assign in_ready_o = a_adv;
  assign nat = (cfg_i.native_int_bytes == 3'd2) ? 4'd2 : 4'd4;

  // field decode
  always_comb begin
    n = 4'd1;
    sgn = 1'b0;
    a_res = 1'b1;
    kind = KIND_UINT;
    val = '0;
    unique case (a_func_q)
      FN_C:  begin val = {56'd0, a_raw_q[7:0]}; kind = KIND_CHAR; end
      FN_F:  begin
        w = join_bytes(a_raw_q, 4'd4, cfg_i.big_endian);
        val = sgl_to_dbl(w[31:0]);
        kind = KIND_DBL;
      end
      FN_D:  begin
        w = join_bytes(a_raw_q, 4'd8, cfg_i.big_endian);
        val = (w[62:52] == 11'h7FF) ? {w[63], 11'h7FF, 52'd0} : w;
        kind = KIND_DBL;
      end
      FN_SB: begin n = 4'd1; sgn = 1'b1; end
      FN_UB: n = 4'd1;
      FN_SH: begin n = 4'd2; sgn = 1'b1; end
      FN_UH: n = 4'd2;
      FN_SL: begin n = 4'd4; sgn = 1'b1; end
      FN_UL: n = 4'd4;
      FN_SI: begin n = nat; sgn = 1'b1; end
      FN_UI: n = nat;
      default: a_res = 1'b0;
    endcase
    w = join_bytes(a_raw_q, n, cfg_i.big_endian);
    if (a_func_q != FN_C && a_func_q != FN_F && a_func_q != FN_D) begin
      val = w;
      if (sgn) begin
        kind = KIND_SINT;
        unique case (n)
          4'd1:    val = {{56{w[7]}}, w[7:0]};
          4'd2:    val = {{48{w[15]}}, w[15:0]};
          default: val = {{32{w[31]}}, w[31:0]};
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_adv) begin
      a_vld_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (a_adv && in_valid_i) begin
      a_func_q <= in_func_i;
      a_raw_q <= in_raw_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_free) begin
      b_vld_q <= a_vld_q & a_res;
    end
  end
  always_ff @(posedge clk_i) begin
    if (b_free && a_vld_q && a_res) begin
      b_val_q <= val;
      b_kind_q <= kind;
    end
  end

  assign out_valid_o = b_vld_q;
  assign out_value_o = b_val_q;
  assign out_kind_o = b_kind_q;

  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni, (a_vld_q && !a_adv) |=> $stable(a_raw_q))
  `ASSERT_CLK(b_stall_hold, clk_i, rst_ni, (b_vld_q && !out_ready_i) |=> (b_vld_q && $stable(b_val_q)))
  `ASSERT_CLK(pad_no_result, clk_i, rst_ni, (a_vld_q && b_free && a_func_q == FN_PAD) |=> !b_vld_q)
endmodule

>>> sv/binary_field_unpacker.sv
// top level of the binary field unpacker
// depends on bfu_pkg, bfu_cfg, bfu_decode
//
// usage:
//  s_axis carries one field per transfer: tdata = raw bytes (64 bits),
//  tuser = format code (4 bits). m_axis returns one result per field that
//  has one: tdata = value (64 bits), tuser = kind (2 bits). pad and
//  unused codes give no result transfer.
//  a field passes the input register, then the result register, before
//  its result is valid; one field is accepted every cycle while the
//  receiver does not stall. when it stalls, the result register holds and
//  the input register takes one more field before tready drops.
//  apb: byte 0 big_endian, byte 4 native_int_bytes; pready always high.
//  reset clears both valid flags and sets little endian, native size 4.
//  configuration is to be written only while no field is in flight; the
//  user must keep to this, the block itself does not enforce it.
module binary_field_unpacker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // raw_bytes[63:0]
  input  logic [3:0]  s_axis_tuser,  // func[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // value[63:0]
  output logic [1:0]  m_axis_tuser   // kind[1:0]
);
  import bfu_pkg::*;
  cfg_t cfg;

  bfu_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  bfu_decode u_dec (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_func_i(s_axis_tuser), .in_raw_i(s_axis_tdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_value_o(m_axis_tdata), .out_kind_o(m_axis_tuser)
  );
endmodule

>>> tb/tb.sv
// self-checking testbench for binary_field_unpacker: directed and random fields
// over apb configuration settings, results checked by a scoreboard class
// depends on bfu_pkg and binary_field_unpacker
`timescale 1ns / 100ps

module tb;
  import bfu_pkg::*;

  // expected results and field decode prediction
  class field_scoreboard;
    logic [63:0] exp_value_q[$];
    kind_e       exp_kind_q[$];
    logic        cfg_be;
    logic [2:0]  cfg_native;
    int          errors;

    function new();
      cfg_be = 1'b0;
      cfg_native = NATIVE_RESET;
      errors = 0;
    endfunction

    function logic [63:0] join_field(logic [63:0] raw, int n);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < n; i++) begin
        if (cfg_be) w = (w << 8) | 64'(raw[8*i +: 8]);
        else w[8*i +: 8] = raw[8*i +: 8];
      end
      return w;
    endfunction

    function logic [63:0] widen_single(logic [31:0] w);
      logic [63:0] r;
      int p;
      r = '0;
      r[63] = w[31];
      if (w[30:23] == 8'd0) begin
        if (w[22:0] == 23'd0) return r;
        p = 22;
        while (!w[p]) p--;
        r[62:52] = 11'(p + 1023 - 149);
        r[51:0] = 52'((64'(w[22:0]) - (64'd1 << p)) << (52 - p));
      end else begin
        r[62:52] = 11'(w[30:23]) + 11'd896;
        r[51:0] = {w[22:0], 29'd0};
      end
      return r;
    endfunction

    // note an accepted field and queue its result, if it has one
    function void note_field(logic [3:0] fn, logic [63:0] raw);
      int n;
      logic sgn;
      logic [63:0] w;
      n = 0;
      sgn = 1'b0;
      case (fn)
        FN_C: begin
          exp_value_q.push_back({56'd0, raw[7:0]});
          exp_kind_q.push_back(KIND_CHAR);
          return;
        end
        FN_F: begin
          exp_value_q.push_back(widen_single(join_field(raw, 4)));
          exp_kind_q.push_back(KIND_DBL);
          return;
        end
        FN_D: begin
          w = join_field(raw, 8);
          if (w[62:52] == 11'h7FF) w = {w[63], 11'h7FF, 52'd0};
          exp_value_q.push_back(w);
          exp_kind_q.push_back(KIND_DBL);
          return;
        end
        FN_SB: begin n = 1; sgn = 1; end
        FN_UB: n = 1;
        FN_SH: begin n = 2; sgn = 1; end
        FN_UH: n = 2;
        FN_SL: begin n = 4; sgn = 1; end
        FN_UL: n = 4;
        FN_SI: begin n = (cfg_native == 3'd2) ? 2 : 4; sgn = 1; end
        FN_UI: n = (cfg_native == 3'd2) ? 2 : 4;
        default: return;
      endcase
      w = join_field(raw, n);
      if (sgn && w[8*n-1]) w = w | (~64'd0 << (8*n));
      exp_value_q.push_back(w);
      exp_kind_q.push_back(sgn ? KIND_SINT : KIND_UINT);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(logic [63:0] value, logic [1:0] kind);
      if (exp_value_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %h kind %0d",
                 $time, value, kind);
        errors++;
        return;
      end
      if (value !== exp_value_q[0] || kind !== exp_kind_q[0]) begin
        $display("%0t: mismatch, expected value %h kind %0d, actual value %h kind %0d",
                 $time, exp_value_q[0], exp_kind_q[0], value, kind);
        errors++;
      end
      void'(exp_value_q.pop_front());
      void'(exp_kind_q.pop_front());
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  field_scoreboard sb = new();
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit snk_hold = 0;

  always #10 clk_i = ~clk_i;

  binary_field_unpacker uut (.*);

  // result side: check transfers, random stalls, optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // write one register during idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_BIG_ENDIAN) sb.cfg_be = val[0];
    else sb.cfg_native = val[2:0];
  endtask

  // offer one field and hold it until the transfer; valid stays high after it
  task automatic send_field(logic [3:0] fn, logic [63:0] raw);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1; s_axis_tuser <= fn; s_axis_tdata <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_field(fn, raw);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_value_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_raw();
    logic [63:0] r;
    logic [63:0] f;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: r = '0;
      1: r = '1;
      2: begin // float/double exponent extremes at little-endian byte positions
        f = {$urandom, $urandom};
        f[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
        r = f;
      end
      3: begin
        f = {32'h0, $urandom};
        f[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
        r = {$urandom, f[31:0]};
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_field(4'($urandom_range(15)), rand_raw());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every code at the extremes, reset settings
    for (int fn = 0; fn < 16; fn++) send_field(4'(fn), 64'h8081_8283_8485_8687);
    send_field(FN_F, 64'h0000_0001);     // smallest subnormal single
    send_field(FN_F, 64'h807F_FFFF);     // largest negative subnormal
    send_field(FN_F, 64'h8000_0000);     // negative zero
    send_field(FN_F, 64'h7FFF_FFFF);     // exponent 255 stays finite
    send_field(FN_D, 64'hFFF8_0000_0000_0001); // top exponent to infinity
    send_field(FN_D, 64'h7FEF_FFFF_FFFF_FFFF);
    send_field(FN_SI, 64'h7F);
    send_field(FN_UI, '1);
    drain();

    write_reg(REG_BIG_ENDIAN, 32'd1);
    write_reg(REG_NATIVE, 32'd2);
    src_idle_pct = 16; snk_idle_pct = 55;
    random_phase(350);

    // long receiver hold-off while the sender keeps offering
    snk_hold = 1;
    fork
      random_phase(20);
      begin repeat (60) @(posedge clk_i); snk_hold = 0; end
    join
    drain(); // sender pause until all results are in

    write_reg(REG_BIG_ENDIAN, 32'hFFFF_FFFE);
    write_reg(REG_NATIVE, 32'd7);
    src_idle_pct = 55; snk_idle_pct = 16;
    random_phase(350);
    drain();

    write_reg(REG_BIG_ENDIAN, 32'd1);
    write_reg(REG_NATIVE, 32'd0);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_phase(200);
    drain();
    write_reg(REG_NATIVE, 32'd4);
    random_phase(150);
    drain();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.exp_value_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
